// ----- rtl/u8d_pkg.sv -----
// shared types, constants and helper functions for the utf-8 decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERLONG = 2'd1,
        STATUS_STRAY    = 2'd2
    } status_t;

    // lead byte classes, the value equals the sequence length for multi-byte leads
    localparam logic [2:0] CLASS_ASCII = 3'd0;
    localparam logic [2:0] CLASS_STRAY = 3'd1;
    localparam logic [2:0] CLASS_TWO   = 3'd2;
    localparam logic [2:0] CLASS_THREE = 3'd3;
    localparam logic [2:0] CLASS_FOUR  = 3'd4;
    localparam logic [2:0] CLASS_FIVE  = 3'd5;
    localparam logic [2:0] CLASS_SIX   = 3'd6;

    localparam logic [7:0] CONT_MASK = 8'h3f;

    typedef struct packed {
        logic        valid;
        logic [31:0] code_point;
        status_t     status;
    } result_t;

    function automatic logic [2:0] lead_class(input logic [7:0] b);
        logic [2:0] n;
        priority if (b <= 8'h7f) n = CLASS_ASCII;
        else if (b <= 8'hbf)     n = CLASS_STRAY;
        else if (b <= 8'hdf)     n = CLASS_TWO;
        else if (b <= 8'hef)     n = CLASS_THREE;
        else if (b <= 8'hf7)     n = CLASS_FOUR;
        else if (b <= 8'hfb)     n = CLASS_FIVE;
        else                     n = CLASS_SIX;
        return n;
    endfunction

    function automatic logic [7:0] payload_mask(input logic [2:0] n);
        logic [7:0] m;
        unique case (n)
            CLASS_ASCII: m = 8'h7f;
            CLASS_STRAY: m = 8'h3f;
            CLASS_TWO:   m = 8'h1f;
            CLASS_THREE: m = 8'h0f;
            CLASS_FOUR:  m = 8'h07;
            default:     m = 8'h03;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] min_value(input logic [2:0] n);
        logic [31:0] v;
        unique case (n)
            CLASS_TWO:   v = 32'h0000_0080;
            CLASS_THREE: v = 32'h0000_0800;
            CLASS_FOUR:  v = 32'h0001_0000;
            CLASS_FIVE:  v = 32'h0020_0000;
            CLASS_SIX:   v = 32'h0400_0000;
            default:     v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/u8d_in_stage.sv -----
// input register stage: holds one byte beat until the decode step takes it
// uses no package
`timescale 1ns / 1ps
`default_nettype none

module u8d_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,
    input  wire logic       consume,
    output logic            item_valid,
    output logic [7:0]      item_byte
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    assign s_axis_tready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

`default_nettype wire

// ----- rtl/u8d_step.sv -----
// decode step: sequence state registers and the per-byte update logic
// depends on u8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8d_step (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] item_byte,
    output u8d_pkg::result_t result
);

    logic [31:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;
    logic [2:0]  lead_n;
    logic [2:0]  len_clamped;

    assign lead_n      = u8d_pkg::lead_class(item_byte);
    assign len_clamped = (len_reg > u8d_pkg::CLASS_SIX) ? u8d_pkg::CLASS_SIX : len_reg;

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        len_next = len_reg;
        if (rem_reg != 3'd0)
        begin
            // continuation position, byte is not checked
            acc_next = {acc_reg[25:0], item_byte[5:0]};
            rem_next = rem_reg - 3'd1;
        end
        else
        begin
            acc_next = {24'd0, item_byte & u8d_pkg::payload_mask(lead_n)};
            len_next = lead_n;
            if (lead_n >= u8d_pkg::CLASS_TWO)
            begin
                rem_next = lead_n - 3'd1;
            end
        end
    end

    always_comb
    begin
        result.valid      = 1'b0;
        result.code_point = acc_next;
        result.status     = u8d_pkg::STATUS_OK;
        if (rem_reg != 3'd0)
        begin
            result.valid = (rem_reg == 3'd1);
            if (acc_next < u8d_pkg::min_value(len_clamped))
            begin
                result.status = u8d_pkg::STATUS_OVERLONG;
            end
        end
        else if (lead_n == u8d_pkg::CLASS_ASCII)
        begin
            result.valid = 1'b1;
        end
        else if (lead_n == u8d_pkg::CLASS_STRAY)
        begin
            result.valid  = 1'b1;
            result.status = u8d_pkg::STATUS_STRAY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 32'd0;
            rem_reg <= 3'd0;
            len_reg <= 3'd0;
        end
        else if (advance)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            len_reg <= len_next;
        end
    end

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd5)
        else $error("bytes remaining above five");

    a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != 3'd0) |-> (len_reg >= u8d_pkg::CLASS_TWO && rem_reg < len_reg))
        else $error("open sequence inconsistent with its length");

    a_stray_six_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == u8d_pkg::STATUS_STRAY)
            |-> (result.code_point[31:6] == 26'd0))
        else $error("stray result wider than six bits");

    a_open_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg > 3'd1) |-> !result.valid)
        else $error("result emitted in the middle of a sequence");

endmodule

`default_nettype wire

// ----- rtl/u8d_out_reg.sv -----
// output result register toward the master-side stream
// depends on u8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire u8d_pkg::result_t result,
    output logic                  free,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [31:0]           m_axis_tdata,
    output logic [1:0]            m_axis_tuser
);

    logic             valid_reg, valid_next;
    logic [31:0]      code_reg;
    u8d_pkg::status_t status_reg;
    logic             load;

    assign free = !valid_reg || m_axis_tready;
    assign load = advance && result.valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg   <= result.code_point;
            status_reg <= result.status;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = code_reg;
    assign m_axis_tuser  = status_reg;

endmodule

`default_nettype wire

// ----- rtl/utf8_to_code_point_decoder.sv -----
// top level of the legacy six-byte utf-8 decoder
// depends on u8d_pkg, u8d_in_stage, u8d_step, u8d_out_reg
//
//   channel   direction  payload                                    beat
//   s_axis    in         tdata[7:0] byte_in                         one raw byte
//   m_axis    out        tdata[31:0] code_point, tuser[1:0] status  one decoded char
//
// one byte beat is taken every cycle while m_axis does not stall; each byte passes an
// input register, the decode logic (shift by six and or, one 32-bit overlong compare)
// and the output register, from which its result leaves. multi-byte leads and
// continuation bytes that do not end a sequence cause no output beat.
// reset clears the open sequence, the accumulator and both valid flags.
// a stall on m_axis holds the decode step only while the output register is
// full and not taken; s_axis stalls once the input register also fills.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_code_point_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] code_point
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    logic             item_valid;
    logic [7:0]       item_byte;
    logic             out_free;
    logic             advance;
    u8d_pkg::result_t result;

    // the decode step moves whenever a byte is held and the result slot can take it
    assign advance = item_valid && out_free;

    u8d_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .consume       (advance),
        .item_valid    (item_valid),
        .item_byte     (item_byte)
    );

    u8d_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_byte (item_byte),
        .result    (result)
    );

    u8d_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .result        (result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
